FILE: sv/lrpc_pkg.sv
// shared types and constants for the rotating lcd pixel converter
// no dependencies; imported by every module of the block
package lrpc_pkg;

  // item kinds
  localparam logic ACT_PALETTE = 1'b0;
  localparam logic ACT_PIXEL   = 1'b1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_MODE   = 3'd0,
    REG_GUEST_WIDTH  = 3'd1,
    REG_GUEST_HEIGHT = 3'd2,
    REG_HOST_WIDTH   = 3'd3,
    REG_HOST_HEIGHT  = 3'd4
  } cfg_reg_t;

  // mono layout select from palette entry 0, bits 13:12
  localparam logic [1:0] LAYOUT_4BPP = 2'd0;
  localparam logic [1:0] LAYOUT_8BPP = 2'd1;

  localparam int OFF_W   = 19;
  localparam int IDX_W   = 22;

  localparam logic [OFF_W-1:0] OFF_COLOR_BASE = 19'h00020;
  localparam logic [OFF_W-1:0] OFF_MONO4_BASE = 19'h00020;
  localparam logic [OFF_W-1:0] OFF_MONO8_BASE = 19'h00200;
  localparam logic [7:0]       ALPHA_OPAQUE   = 8'hFF;

  // dither value to gray intensity
  localparam logic [7:0] MONO_GRAY [16] = '{
    8'd255, 8'd227, 8'd204, 8'd187, 8'd170, 8'd153, 8'd142, 8'd127,
    8'd113, 8'd102, 8'd85,  8'd68,  8'd51,  8'd28,  8'd0,   8'd0
  };

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

  // transaction after the address stages
  typedef struct packed {
    logic             action;
    logic             in_clip;
    logic [7:0]       pidx;
    logic [15:0]      pent;
    logic [15:0]      data;
    logic [IDX_W-1:0] idx;
  } addr_item_t;

endpackage

FILE: sv/lrpc_addr.sv
// address stages: clip test and rotation (stage 1), source pixel index multiply (stage 2)
// depends on lrpc_pkg
module lrpc_addr import lrpc_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int PANEL_LINES = 240
) (
  input  logic        clk,
  input  logic        rst,
  input  pipe_en_t    en,
  input  logic        in_valid,
  input  logic        action,
  input  logic [7:0]  palette_index,
  input  logic [15:0] palette_entry,
  input  logic [9:0]  dest_x,
  input  logic [9:0]  dest_y,
  input  logic [15:0] source_data,
  input  logic        color_mode,
  input  logic [10:0] guest_width,
  input  logic [7:0]  guest_height,
  input  logic [10:0] host_width,
  input  logic [10:0] host_height,
  output logic        v1,
  output logic        v2,
  output addr_item_t  item
);

  logic [10:0] gw;
  logic [7:0]  gh;
  logic [10:0] dx_ext;
  logic [10:0] dy_ext;
  logic        in_clip;
  logic [9:0]  ys_op;
  logic [10:0] xs_op;

  logic        a1;
  logic        in1;
  logic [7:0]  pidx1;
  logic [15:0] pent1;
  logic [15:0] data1;
  logic [9:0]  ys1;
  logic [10:0] xs1;
  logic [20:0] prod;

  // clamped source size; the clamp only applies when the limit fits the register
  assign gw = (32'(guest_width) > MAX_WIDTH) ? 11'(MAX_WIDTH) : guest_width;
  assign gh = (32'(guest_height) > PANEL_LINES) ? 8'(PANEL_LINES) : guest_height;

  assign dx_ext = {1'b0, dest_x};
  assign dy_ext = {1'b0, dest_y};
  assign in_clip = (dx_ext < host_width) && (dx_ext < {3'b000, gh}) &&
                   (dy_ext < host_height) && (dy_ext < gw);

  // colour turns counter-clockwise, mono clockwise
  always_comb begin
    if (color_mode) begin
      ys_op = dest_x;
      xs_op = gw - 11'd1 - dy_ext;
    end else begin
      ys_op = {2'b00, gh} - 10'd1 - dest_x;
      xs_op = dy_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en.s1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      a1    <= action;
      in1   <= in_clip;
      pidx1 <= palette_index;
      pent1 <= palette_entry;
      data1 <= source_data;
      ys1   <= ys_op;
      xs1   <= xs_op;
    end
  end

  assign prod = 21'(ys1) * 21'(gw);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en.s2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      item.action  <= a1;
      item.in_clip <= in1;
      item.pidx    <= pidx1;
      item.pent    <= pent1;
      item.data    <= data1;
      item.idx     <= {1'b0, prod} + 22'(xs1);
    end
  end

endmodule

FILE: sv/lrpc_lookup.sv
// stage 3: palette store, layout state, offset select, rgb565 expand and gray lookup
// depends on lrpc_pkg
module lrpc_lookup import lrpc_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  pipe_en_t         en,
  input  logic             v2,
  input  addr_item_t       item,
  input  logic             color_mode,
  output logic             v3,
  output logic [31:0]      pixel_argb,
  output logic [OFF_W-1:0] source_offset,
  output logic             layout_error
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [7:0] gray_mem [PALETTE_DEPTH];

  logic             eight_bit_layout;
  logic             eight_bit_next;
  logic             bad_layout;
  logic             bad_layout_next;
  logic             pal_wr;
  logic             mem_we;
  logic             pix;
  logic             color_hit;
  logic             mono_hit;
  logic [3:0]       nib;
  logic [7:0]       gray_idx;
  logic             in_range;
  logic [OFF_W-1:0] off_next;
  logic [31:0]      base_next;

  logic             look3;
  logic             rng3;
  logic [7:0]       rdata;
  logic [31:0]      base3;
  logic [OFF_W-1:0] off3;
  logic             err3;
  logic [7:0]       gray;

  function automatic logic [31:0] expand_rgb565(input logic [15:0] p);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = p[15:11];
    g6 = p[10:5];
    b5 = p[4:0];
    return {ALPHA_OPAQUE, r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
  endfunction

  assign pal_wr = en.s3 && v2 && (item.action == ACT_PALETTE);
  assign mem_we = pal_wr && (32'(item.pidx) < PALETTE_DEPTH);

  // entry 0 picks the mono layout, even when the store itself is too shallow
  always_comb begin
    eight_bit_next  = eight_bit_layout;
    bad_layout_next = bad_layout;
    if (pal_wr && (item.pidx == 8'd0)) begin
      unique case (item.pent[13:12])
        LAYOUT_4BPP: begin
          eight_bit_next  = 1'b0;
          bad_layout_next = 1'b0;
        end
        LAYOUT_8BPP: begin
          eight_bit_next  = 1'b1;
          bad_layout_next = 1'b0;
        end
        default: begin
          bad_layout_next = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eight_bit_layout <= 1'b0;
      bad_layout       <= 1'b0;
    end else begin
      eight_bit_layout <= eight_bit_next;
      bad_layout       <= bad_layout_next;
    end
  end

  assign pix       = (item.action == ACT_PIXEL) && item.in_clip;
  assign color_hit = pix && color_mode;
  assign mono_hit  = pix && !color_mode && !bad_layout;

  // odd index takes the high nibble
  assign nib      = item.idx[0] ? item.data[7:4] : item.data[3:0];
  assign gray_idx = eight_bit_layout ? item.data[7:0] : {4'h0, nib};
  assign in_range = 32'(gray_idx) < PALETTE_DEPTH;

  always_comb begin
    off_next  = '0;
    base_next = '0;
    if (color_hit) begin
      off_next  = OFF_COLOR_BASE + {item.idx[OFF_W-2:0], 1'b0};
      base_next = expand_rgb565(item.data);
    end else if (mono_hit) begin
      if (eight_bit_layout) begin
        off_next = OFF_MONO8_BASE + item.idx[OFF_W-1:0];
      end else begin
        off_next = OFF_MONO4_BASE + item.idx[OFF_W:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      gray_mem[item.pidx[AW-1:0]] <= MONO_GRAY[item.pent[3:0]];
    end
    if (en.s3) begin
      rdata <= gray_mem[gray_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en.s3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      look3 <= mono_hit;
      rng3  <= in_range;
      base3 <= base_next;
      off3  <= off_next;
      err3  <= bad_layout_next;
    end
  end

  assign gray          = rng3 ? rdata : 8'd0;
  assign pixel_argb    = look3 ? {ALPHA_OPAQUE, gray, gray, gray} : base3;
  assign source_offset = off3;
  assign layout_error  = err3;

endmodule

FILE: sv/lcd_rotating_pixel_converter.sv
// top level of the rotating lcd pixel converter: config registers, stall chain, assertions
// depends on lrpc_pkg, lrpc_addr and lrpc_lookup
//
//   channel  direction  handshake               payload
//   cfg      in         cfg_write               cfg_index, cfg_data
//   in       in         in_valid / in_stall     action, palette_index, palette_entry,
//                                               dest_x, dest_y, source_data
//   out      out        out_valid / out_stall   pixel_argb, source_offset, layout_error
//
// one transaction per clock while the output is not stalled; three register stages,
// so a result is presented once its item has passed all three; out_stall low takes it.
// the palette store (one write, one registered read per cycle) sits in stage three.
// reset clears the valid bits and the layout state and loads the config register defaults;
// palette entries hold nothing defined until written.
// each stage with an empty slot keeps moving while the output stalls.
module lcd_rotating_pixel_converter import lrpc_pkg::*; #(
  parameter int MAX_WIDTH     = 1024,
  parameter int PANEL_LINES   = 240,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  action,
  input  logic [7:0]            palette_index,
  input  logic [15:0]           palette_entry,
  input  logic [9:0]            dest_x,
  input  logic [9:0]            dest_y,
  input  logic [15:0]           source_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           pixel_argb,
  output logic [OFF_W-1:0]      source_offset,
  output logic                  layout_error
);

  logic        color_mode;
  logic [10:0] guest_width;
  logic [7:0]  guest_height;
  logic [10:0] host_width;
  logic [10:0] host_height;

  pipe_en_t   en;
  logic       v1;
  logic       v2;
  logic       v3;
  addr_item_t item;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode   <= 1'b1;
      guest_width  <= 11'd320;
      guest_height <= 8'd240;
      host_width   <= 11'd240;
      host_height  <= 11'd320;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COLOR_MODE:   color_mode   <= cfg_data[0];
        REG_GUEST_WIDTH:  guest_width  <= cfg_data;
        REG_GUEST_HEIGHT: guest_height <= cfg_data[7:0];
        REG_HOST_WIDTH:   host_width   <= cfg_data;
        REG_HOST_HEIGHT:  host_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or the stage after it moves
  assign en.s3    = !v3 || !out_stall;
  assign en.s2    = !v2 || en.s3;
  assign en.s1    = !v1 || en.s2;
  assign in_stall = !en.s1;
  assign out_valid = v3;

  lrpc_addr #(
    .MAX_WIDTH   (MAX_WIDTH),
    .PANEL_LINES (PANEL_LINES)
  ) u_addr (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (in_valid),
    .action        (action),
    .palette_index (palette_index),
    .palette_entry (palette_entry),
    .dest_x        (dest_x),
    .dest_y        (dest_y),
    .source_data   (source_data),
    .color_mode    (color_mode),
    .guest_width   (guest_width),
    .guest_height  (guest_height),
    .host_width    (host_width),
    .host_height   (host_height),
    .v1            (v1),
    .v2            (v2),
    .item          (item)
  );

  lrpc_lookup #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_lookup (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .v2            (v2),
    .item          (item),
    .color_mode    (color_mode),
    .v3            (v3),
    .pixel_argb    (pixel_argb),
    .source_offset (source_offset),
    .layout_error  (layout_error)
  );

`ifndef SYNTHESIS
  // input side only backs up when every stage is full and the output is stalled
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && v3 && out_stall))
    else $error("input stalled with an empty pipeline slot");

  // any nonzero pixel is an opaque converted pixel
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (pixel_argb != 32'd0)) |-> (pixel_argb[31:24] == ALPHA_OPAQUE))
    else $error("converted pixel without opaque alpha");

  // an offset is only reported together with a converted pixel
  a_offset_pixel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (source_offset != '0)) |-> (pixel_argb[31:24] == ALPHA_OPAQUE))
    else $error("source offset reported without a converted pixel");
`endif

endmodule
